// ===== rtl/twd_pkg.sv =====
`default_nettype none
package twd_pkg;

    localparam int DW = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RANK,
        ST_SCAN,
        ST_DRAIN,
        ST_BIT,
        ST_WRD0,
        ST_WRD1,
        ST_WCAP,
        ST_MUL,
        ST_CHK,
        ST_DIV
    } state_t;

    localparam logic [1:0] REG_TARGET     = 2'd0;
    localparam logic [1:0] REG_RST_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RST_VALUE  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ARITH = 2'd1;
    localparam logic [1:0] STAT_DROP  = 2'd2;

    typedef struct packed {
        logic setup;
        logic rank;
        logic scan;
        logic bit_upd;
        logic wrd0;
        logic wrd1;
        logic wcap;
        logic mul;
        logic fin_short;
        logic fin_ovf;
        logic div_start;
        logic fin_div;
    } cmd_t;

    typedef struct packed {
        logic short_list;
        logic scan_last;
        logic last_bit;
        logic arith_ovf;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/twd_ram.sv =====
`default_nettype none
module twd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/twd_div.sv =====
`default_nettype none
module twd_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [twd_pkg::DW-1:0] dividend,
    input  wire logic [twd_pkg::DW-1:0] divisor,
    output logic                       done,
    output logic [twd_pkg::DW-1:0]     quotient
);

    localparam int DW = twd_pkg::DW;
    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;

    // restoring divider, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_reg <= diff[DW-1:0];
            end else begin
                rem_reg <= trial[DW-1:0];
            end
            quo_reg <= {quo_reg[DW-2:0], ~diff[DW]};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/twd_ctrl.sv =====
`default_nettype none
module twd_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire twd_pkg::stat_t st,
    output twd_pkg::cmd_t       cmd,
    output logic                idle
);

    twd_pkg::state_t state_reg;
    twd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= twd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            twd_pkg::ST_IDLE:  if (start) state_next = twd_pkg::ST_SETUP;
            twd_pkg::ST_SETUP: state_next = twd_pkg::ST_RANK;
            twd_pkg::ST_RANK: begin
                state_next = st.short_list ? twd_pkg::ST_IDLE : twd_pkg::ST_SCAN;
            end
            twd_pkg::ST_SCAN:  if (st.scan_last) state_next = twd_pkg::ST_DRAIN;
            twd_pkg::ST_DRAIN: state_next = twd_pkg::ST_BIT;
            twd_pkg::ST_BIT: begin
                state_next = st.last_bit ? twd_pkg::ST_WRD0 : twd_pkg::ST_SCAN;
            end
            twd_pkg::ST_WRD0:  state_next = twd_pkg::ST_WRD1;
            twd_pkg::ST_WRD1:  state_next = twd_pkg::ST_WCAP;
            twd_pkg::ST_WCAP:  state_next = twd_pkg::ST_MUL;
            twd_pkg::ST_MUL:   state_next = twd_pkg::ST_CHK;
            twd_pkg::ST_CHK: begin
                state_next = st.arith_ovf ? twd_pkg::ST_IDLE : twd_pkg::ST_DIV;
            end
            twd_pkg::ST_DIV:   if (st.div_done) state_next = twd_pkg::ST_IDLE;
            default:           state_next = twd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd  = '0;
        idle = 1'b0;
        case (state_reg)
            twd_pkg::ST_IDLE:  idle = 1'b1;
            twd_pkg::ST_SETUP: cmd.setup = 1'b1;
            twd_pkg::ST_RANK: begin
                cmd.fin_short = st.short_list;
                cmd.rank      = ~st.short_list;
            end
            twd_pkg::ST_SCAN:  cmd.scan = 1'b1;
            twd_pkg::ST_DRAIN: cmd = '0;
            twd_pkg::ST_BIT:   cmd.bit_upd = 1'b1;
            twd_pkg::ST_WRD0:  cmd.wrd0 = 1'b1;
            twd_pkg::ST_WRD1:  cmd.wrd1 = 1'b1;
            twd_pkg::ST_WCAP:  cmd.wcap = 1'b1;
            twd_pkg::ST_MUL:   cmd.mul = 1'b1;
            twd_pkg::ST_CHK: begin
                cmd.fin_ovf   = st.arith_ovf;
                cmd.div_start = ~st.arith_ovf;
            end
            twd_pkg::ST_DIV:   cmd.fin_div = st.div_done;
            default:           cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/twd_dp.sv =====
`default_nettype none
module twd_dp #(
    parameter int WINDOW   = 720,
    parameter int CUT      = 60,
    parameter int MAX_LOAD = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   accept,
    input  wire logic [twd_pkg::DW-1:0] in_time,
    input  wire logic [twd_pkg::DW-1:0] in_work,
    input  wire logic [twd_pkg::DW-1:0] in_height,
    input  wire logic                   in_last,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [twd_pkg::DW-1:0] cfg_data,
    input  wire twd_pkg::cmd_t          cmd,
    output twd_pkg::stat_t              st,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [twd_pkg::DW-1:0]      next_diff,
    output logic [1:0]                  status
);

    localparam int DW    = twd_pkg::DW;
    localparam int CNT_W = $clog2(MAX_LOAD + 1);
    localparam int AW    = $clog2(MAX_LOAD);
    localparam int KEEP  = (2 * CUT > WINDOW - 2) ? 2 : WINDOW - 2 * CUT;
    localparam logic [31:0] KEEP_U = 32'(KEEP);

    // configuration
    logic [15:0]    target_reg;
    logic [DW-1:0]  rst_height_reg;
    logic [DW-1:0]  rst_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= 16'd120;
            rst_height_reg <= '0;
            rst_value_reg  <= 64'd1;
        end else if (cfg_we) begin
            case (cfg_addr)
                twd_pkg::REG_TARGET:     target_reg     <= cfg_data[15:0];
                twd_pkg::REG_RST_HEIGHT: rst_height_reg <= cfg_data;
                twd_pkg::REG_RST_VALUE:  rst_value_reg  <= cfg_data;
                default:                 target_reg     <= target_reg;
            endcase
        end
    end

    // load side
    logic [CNT_W-1:0] load_cnt_reg;
    logic             load_ovf_reg;
    logic [DW-1:0]    height_reg;
    logic             wr_en;
    logic             fin;

    assign wr_en = accept && (32'(load_cnt_reg) < 32'(MAX_LOAD));
    assign fin   = cmd.fin_short || cmd.fin_ovf || cmd.fin_div;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            load_ovf_reg <= 1'b0;
        end else if (fin) begin
            load_cnt_reg <= '0;
            load_ovf_reg <= 1'b0;
        end else if (accept) begin
            if (wr_en) begin
                load_cnt_reg <= load_cnt_reg + 1'b1;
            end else begin
                load_ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_last) begin
            height_reg <= in_height;
        end
    end

    // window setup
    logic [DW-1:0]    height_gap;
    logic             do_rst;
    logic [CNT_W-1:0] len_pre;
    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] start_next;
    logic [CNT_W-1:0] start_reg;
    logic [CNT_W-1:0] len_reg;
    logic             did_rst_reg;

    assign height_gap = height_reg - rst_height_reg;
    assign do_rst = (rst_height_reg != '0) && (height_reg >= rst_height_reg)
                    && (height_gap < DW'(load_cnt_reg));

    always_comb begin
        len_pre    = do_rst ? height_gap[CNT_W-1:0] : load_cnt_reg;
        start_next = do_rst ? load_cnt_reg - height_gap[CNT_W-1:0] : '0;
        len_next   = len_pre;
        if (32'(len_pre) > 32'(WINDOW)) begin
            len_next = CNT_W'(WINDOW);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            start_reg   <= start_next;
            len_reg     <= len_next;
            did_rst_reg <= do_rst;
        end
    end

    // trim positions
    logic [31:0]      lo_wide;
    logic [CNT_W-1:0] pos0_next;
    logic [CNT_W-1:0] pos1_next;
    logic [CNT_W-1:0] pos0_reg;
    logic [CNT_W-1:0] pos1_reg;

    always_comb begin
        lo_wide = (32'(len_reg) - KEEP_U + 32'd1) >> 1;
        if (32'(len_reg) <= KEEP_U) begin
            pos0_next = '0;
            pos1_next = len_reg - 1'b1;
        end else begin
            pos0_next = CNT_W'(lo_wide);
            pos1_next = CNT_W'(lo_wide + KEEP_U - 32'd1);
        end
    end

    // bitwise order-statistic selection, both ranks in one scan per bit
    logic [DW-1:0]    pre0_reg;
    logic [DW-1:0]    pre1_reg;
    logic [DW-1:0]    hmask_reg;
    logic [DW-1:0]    bsel_reg;
    logic [CNT_W-1:0] rk0_reg;
    logic [CNT_W-1:0] rk1_reg;
    logic [CNT_W-1:0] cnt0_reg;
    logic [CNT_W-1:0] cnt1_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             vld_reg;
    logic [DW-1:0]    time_q;
    logic             hit0;
    logic             hit1;

    assign hit0 = (((time_q ^ pre0_reg) & hmask_reg) == '0) && ((time_q & bsel_reg) == '0);
    assign hit1 = (((time_q ^ pre1_reg) & hmask_reg) == '0) && ((time_q & bsel_reg) == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rank) begin
            pos0_reg  <= pos0_next;
            pos1_reg  <= pos1_next;
            rk0_reg   <= pos0_next;
            rk1_reg   <= pos1_next;
            pre0_reg  <= '0;
            pre1_reg  <= '0;
            hmask_reg <= '0;
            bsel_reg  <= {1'b1, {(DW-1){1'b0}}};
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
            idx_reg   <= '0;
        end else if (cmd.bit_upd) begin
            if (rk0_reg >= cnt0_reg) begin
                pre0_reg <= pre0_reg | bsel_reg;
                rk0_reg  <= rk0_reg - cnt0_reg;
            end
            if (rk1_reg >= cnt1_reg) begin
                pre1_reg <= pre1_reg | bsel_reg;
                rk1_reg  <= rk1_reg - cnt1_reg;
            end
            hmask_reg <= hmask_reg | bsel_reg;
            bsel_reg  <= bsel_reg >> 1;
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.scan) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (vld_reg) begin
                cnt0_reg <= cnt0_reg + CNT_W'(hit0);
                cnt1_reg <= cnt1_reg + CNT_W'(hit1);
            end
        end
    end

    // stores
    logic [AW-1:0] time_raddr;
    logic [AW-1:0] work_raddr;
    logic [DW-1:0] work_q;

    assign time_raddr = AW'(start_reg + idx_reg);
    assign work_raddr = AW'(start_reg + (cmd.wrd0 ? pos0_reg : pos1_reg));

    twd_ram #(.WIDTH(DW), .DEPTH(MAX_LOAD)) u_time_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (AW'(load_cnt_reg)),
        .wdata (in_time),
        .raddr (time_raddr),
        .rdata (time_q)
    );

    twd_ram #(.WIDTH(DW), .DEPTH(MAX_LOAD)) u_work_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (AW'(load_cnt_reg)),
        .wdata (in_work),
        .raddr (work_raddr),
        .rdata (work_q)
    );

    // arithmetic
    logic [DW-1:0]    w0_reg;
    logic [DW-1:0]    w1_reg;
    logic [DW-1:0]    span_diff;
    logic [DW-1:0]    span_reg;
    logic [DW+15:0]   prod_reg;
    logic [DW-1:0]    work_diff;
    logic [DW:0]      sum;
    logic             div_done;
    logic [DW-1:0]    quotient;

    assign span_diff = pre1_reg - pre0_reg;
    assign work_diff = w1_reg - w0_reg;
    assign sum       = {1'b0, prod_reg[DW-1:0]} + {1'b0, span_reg - 1'b1};

    always_ff @(posedge aclk) begin
        if (cmd.wrd1) begin
            w0_reg <= work_q;
        end
        if (cmd.wcap) begin
            w1_reg <= work_q;
        end
        if (cmd.mul) begin
            span_reg <= (span_diff == '0) ? DW'(1) : span_diff;
            prod_reg <= (DW+16)'(work_diff) * (DW+16)'(target_reg);
        end
    end

    twd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum[DW-1:0]),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // result word
    logic          out_valid_reg;
    logic [DW-1:0] diff_reg;
    logic [1:0]    status_reg;
    logic [1:0]    drop_status;

    assign drop_status = load_ovf_reg ? twd_pkg::STAT_DROP : twd_pkg::STAT_OK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fin) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_short) begin
            diff_reg   <= did_rst_reg ? rst_value_reg : DW'(1);
            status_reg <= drop_status;
        end else if (cmd.fin_ovf) begin
            diff_reg   <= '0;
            status_reg <= twd_pkg::STAT_ARITH;
        end else if (cmd.fin_div) begin
            diff_reg   <= quotient;
            status_reg <= drop_status;
        end
    end

    assign st.short_list = (len_reg <= CNT_W'(1));
    assign st.scan_last  = (idx_reg == len_reg - 1'b1);
    assign st.last_bit   = bsel_reg[0];
    assign st.arith_ovf  = (prod_reg[DW+15:DW] != '0) || sum[DW];
    assign st.div_done   = div_done;

    assign out_valid = out_valid_reg;
    assign next_diff = diff_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

// ===== rtl/trimmed_window_difficulty.sv =====
// Each accepted word is stored, up to MAX_LOAD per list; later words are dropped.
// A final word starts the evaluation: a list of one kept pair or fewer answers
// once the SETUP and RANK states have passed; otherwise the time is set by the 64
// bitwise selection scans over the single time-store read port and the divider.
// Reset (aresetn, synchronous, active low) clears control, counters, result valid
// and config to defaults; store and datapath data are kept, no clearing pass.
`default_nettype none
module trimmed_window_difficulty #(
    parameter int WINDOW   = 720,
    parameter int CUT      = 60,
    parameter int MAX_LOAD = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [191:0]  s_tdata,   // timestamp, cum_difficulty, chain_height
    input  wire logic          s_tlast,   // last_pair
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,   // next_diff, status, zero fill
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [63:0]   cfg_data
);

    twd_pkg::cmd_t  cmd;
    twd_pkg::stat_t st;
    logic           idle;
    logic           accept;
    logic [63:0]    next_diff;
    logic [1:0]     status;

    // a final word waits while the previous result is still held
    assign s_tready  = idle && !(m_tvalid && s_tlast);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = idle;

    twd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_tlast),
        .st      (st),
        .cmd     (cmd),
        .idle    (idle)
    );

    twd_dp #(
        .WINDOW   (WINDOW),
        .CUT      (CUT),
        .MAX_LOAD (MAX_LOAD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_time   (s_tdata[63:0]),
        .in_work   (s_tdata[127:64]),
        .in_height (s_tdata[191:128]),
        .in_last   (s_tlast),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .next_diff (next_diff),
        .status    (status)
    );

    assign m_tdata = {6'b0, status, next_diff};

endmodule
`default_nettype wire

// ===== rtl/twd_chk.sv =====
`default_nettype none
module twd_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         s_tlast,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:64] == twd_pkg::STAT_OK)
                  || (m_tdata[65:64] == twd_pkg::STAT_ARITH)
                  || (m_tdata[65:64] == twd_pkg::STAT_DROP))
        else $error("bad status code");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] == twd_pkg::STAT_ARITH) |-> m_tdata[63:0] == 64'd0)
        else $error("overflow result not zero");

    a_last_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && s_tvalid && s_tlast |-> !s_tready)
        else $error("final word taken while a result is pending");

endmodule

bind trimmed_window_difficulty twd_chk u_chk (.*);
`default_nettype wire
